/* design/ipv4_frame_header_validator_defines.svh */
// assertion helpers for the top-level design file
`ifndef IPV4_FRAME_HEADER_VALIDATOR_DEFINES_SVH
`define IPV4_FRAME_HEADER_VALIDATOR_DEFINES_SVH

// same-cycle implication under the active-low reset
`define IFHV_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication under the active-low reset
`define IFHV_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/ifhv_pkg.sv */
package ifhv_pkg;

  localparam int unsigned CountBits = 17;

  typedef logic [CountBits-1:0] count_t;

  localparam count_t EthHdrLen   = count_t'(14);
  localparam count_t MinFrameLen = count_t'(34);

  // header byte offsets from the start of the frame
  localparam count_t OffVerIhl  = EthHdrLen;
  localparam count_t OffLenHi   = EthHdrLen + count_t'(2);
  localparam count_t OffLenLo   = EthHdrLen + count_t'(3);
  localparam count_t OffTtl     = EthHdrLen + count_t'(8);

  localparam logic [3:0]  VersionV4 = 4'd4;
  localparam logic [3:0]  MinIhl    = 4'd5;
  localparam logic [15:0] SumGood   = 16'hFFFF;

  // one buffered input item between the input stage and the core
  typedef struct packed {
    logic       valid;
    logic [7:0] frame_byte;
    logic       last_byte;
  } ifhv_stage_t;

endpackage

/* design/ifhv_if.sv */
interface ifhv_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, output frame_byte, output last_byte, input ready);
  modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

interface ifhv_res_if;
  logic valid;
  logic ready;
  logic frame_ok;

  modport source (output valid, output frame_ok, input ready);
  modport sink   (input valid, input frame_ok, output ready);
endinterface

/* design/ipv4_frame_header_validator.sv */
// IPv4 header validator for a byte-wide Ethernet frame stream. One byte is
// accepted per clock, with no gaps needed between frames, while no final byte
// is stalled; the header starts at frame byte 14. Each byte passes through an
// input register and then the core logic, whose longest path is the 16-bit
// end-around-carry checksum add, so the sustained rate is one byte per cycle.
// The pass/fail result is registered as the core takes a frame's last byte from
// the input register and is held until taken; while it waits, non-final bytes
// of the next frame keep flowing and that frame's last byte stalls. The frame
// fails if it is under 34 bytes, the version is not 4, IHL is below 5, total
// length is below IHL*4 or runs past the frame, TTL is zero, or the header
// checksum does not fold to all ones. No clearing pass follows reset.
`include "ipv4_frame_header_validator_defines.svh"

module ipv4_frame_header_validator
  import ifhv_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  ifhv_byte_if.sink  frame_i,
  ifhv_res_if.source result_o
);

  ifhv_stage_t stage;
  logic        take;

  ifhv_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .frame_i (frame_i),
    .take_i  (take),
    .stage_o (stage)
  );

  ifhv_hdr_core u_hdr_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .stage_i  (stage),
    .take_o   (take),
    .result_o (result_o)
  );

  // refilling a full input stage only happens while its item moves on
  `IFHV_ASSERT_NOW(a_refill_takes, clk_i, rst_ni,
                   frame_i.valid && frame_i.ready && stage.valid, take,
                   "input stage overwritten")
  // mid-frame bytes never wait on the result channel
  `IFHV_ASSERT_NOW(a_mid_no_stall, clk_i, rst_ni,
                   stage.valid && !stage.last_byte, take,
                   "non-final item stalled")
  // taking a final byte always yields a result next cycle
  `IFHV_ASSERT_NXT(a_last_gives_result, clk_i, rst_ni,
                   take && stage.last_byte, result_o.valid,
                   "final item produced no result")

endmodule

/* design/ifhv_in_stage.sv */
module ifhv_in_stage
  import ifhv_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  ifhv_byte_if.sink           frame_i,
  input  logic                take_i,
  output ifhv_stage_t         stage_o
);

  logic       vld_q, vld_d;
  logic [7:0] byte_q;
  logic       last_q;
  logic       load;

  assign frame_i.ready = !vld_q || take_i;
  assign load          = frame_i.valid && frame_i.ready;

  always_comb begin
    vld_d = vld_q;
    if (load) begin
      vld_d = 1'b1;
    end else if (take_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= frame_i.frame_byte;
      last_q <= frame_i.last_byte;
    end
  end

  assign stage_o = '{valid: vld_q, frame_byte: byte_q, last_byte: last_q};

endmodule

/* design/ifhv_hdr_core.sv */
module ifhv_hdr_core
  import ifhv_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ifhv_stage_t         stage_i,
  output logic                take_o,
  ifhv_res_if.source          result_o
);

  count_t      count_q, count_d;
  logic [3:0]  hw_q, hw_d;
  logic        ver_q, ver_d;
  logic [15:0] len_q, len_d;
  logic        ttl0_q, ttl0_d;
  logic [15:0] sum_q, sum_d;
  logic [7:0]  pend_q, pend_d;
  logic        res_vld_q, res_vld_d;
  logic        res_ok_q, res_ok_d;

  count_t      after;
  count_t      hdr_end;
  count_t      len_end;
  logic        in_sum;
  logic [16:0] sum_raw;
  logic        ok;

  // a non-final item never needs the result register
  assign take_o = stage_i.valid &&
                  (!stage_i.last_byte || !res_vld_q || result_o.ready);

  always_comb begin
    after   = (&count_q) ? count_q : count_q + count_t'(1);
    hdr_end = EthHdrLen + count_t'({hw_q, 2'b00});
    in_sum  = (count_q == EthHdrLen) ||
              (count_q >= EthHdrLen && count_q < hdr_end);

    hw_d   = hw_q;
    ver_d  = ver_q;
    len_d  = len_q;
    ttl0_d = ttl0_q;
    sum_d  = sum_q;
    pend_d = pend_q;

    if (count_q == OffVerIhl) begin
      ver_d = (stage_i.frame_byte[7:4] == VersionV4);
      hw_d  = stage_i.frame_byte[3:0];
    end
    if (count_q == OffLenHi) begin
      len_d[15:8] = stage_i.frame_byte;
    end
    if (count_q == OffLenLo) begin
      len_d[7:0] = stage_i.frame_byte;
    end
    if (count_q == OffTtl) begin
      ttl0_d = (stage_i.frame_byte == 8'd0);
    end

    // header starts at an even offset, so count parity gives the byte lane
    sum_raw = {1'b0, sum_q} + {1'b0, pend_q, stage_i.frame_byte};
    if (in_sum) begin
      if (!count_q[0]) begin
        pend_d = stage_i.frame_byte;
      end else begin
        sum_d = sum_raw[15:0] + {15'd0, sum_raw[16]};
      end
    end

    len_end = count_t'({{(CountBits-16){1'b0}}, len_d}) + EthHdrLen;
    ok = (after >= MinFrameLen) && ver_d && (hw_d >= MinIhl) &&
         (len_d >= {10'd0, hw_d, 2'b00}) && (len_end <= after) &&
         !ttl0_d && (sum_d == SumGood);

    count_d   = after;
    res_ok_d  = res_ok_q;
    res_vld_d = res_vld_q && !result_o.ready;
    if (take_o && stage_i.last_byte) begin
      res_vld_d = 1'b1;
      res_ok_d  = ok;
      count_d   = '0;
      hw_d      = '0;
      ver_d     = 1'b0;
      len_d     = '0;
      ttl0_d    = 1'b0;
      sum_d     = '0;
      pend_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      hw_q      <= '0;
      ver_q     <= 1'b0;
      len_q     <= '0;
      ttl0_q    <= 1'b0;
      sum_q     <= '0;
      pend_q    <= '0;
      res_vld_q <= 1'b0;
    end else begin
      if (take_o) begin
        count_q <= count_d;
        hw_q    <= hw_d;
        ver_q   <= ver_d;
        len_q   <= len_d;
        ttl0_q  <= ttl0_d;
        sum_q   <= sum_d;
        pend_q  <= pend_d;
      end
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_ok_q <= res_ok_d;
  end

  assign result_o.valid    = res_vld_q;
  assign result_o.frame_ok = res_ok_q;

endmodule

/* tb/sv/ipv4_header_verdict_checker.sv */
`timescale 1ns / 100ps

module ipv4_header_verdict_checker
  import ifhv_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  ifhv_byte_if        frame_i,
  ifhv_res_if         result_i,
  output int unsigned mismatches_o,
  output int unsigned awaiting_o
);

  typedef struct {
    logic        frame_ok;
    int unsigned frame_no;
  } verdict_t;

  verdict_t    expected_verdicts[$];
  int unsigned mismatch_total = 0;
  int unsigned frames_closed = 0;

  // running view of the frame in flight
  count_t      bytes_seen;
  logic [3:0]  ihl_words;
  logic        version_is_4;
  logic [15:0] ip_total_len;
  logic        ttl_is_zero;
  logic [15:0] hdr_sum;
  logic [7:0]  sum_hi_byte;

  assign mismatches_o = mismatch_total;

  function automatic void clear_frame_state();
    bytes_seen   = '0;
    ihl_words    = '0;
    version_is_4 = 1'b0;
    ip_total_len = '0;
    ttl_is_zero  = 1'b0;
    hdr_sum      = '0;
    sum_hi_byte  = '0;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns checker: %s", $time, msg);
    mismatch_total++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    count_t      offs;
    count_t      seen;
    logic [16:0] s;
    logic [7:0]  b;
    logic        ok;
    verdict_t    v;
    if (!rst_ni) begin
      clear_frame_state();
      expected_verdicts.delete();
      awaiting_o <= 0;
    end else begin
      // a result taken at this edge always belongs to an earlier frame
      if (result_i.valid && result_i.ready) begin
        if (expected_verdicts.size() == 0) begin
          report_mismatch($sformatf("frame_ok=%0b with no frame waiting", result_i.frame_ok));
        end else begin
          v = expected_verdicts.pop_front();
          if (result_i.frame_ok !== v.frame_ok) begin
            report_mismatch($sformatf("frame %0d: frame_ok=%0b, expected %0b",
                                      v.frame_no, result_i.frame_ok, v.frame_ok));
          end
        end
      end

      if (frame_i.valid && frame_i.ready) begin
        b = frame_i.frame_byte;
        seen = (bytes_seen == '1) ? bytes_seen : bytes_seen + count_t'(1);
        if (bytes_seen >= EthHdrLen) begin
          offs = bytes_seen - EthHdrLen;
          if (offs == 0) begin
            version_is_4 = (b[7:4] == VersionV4);
            ihl_words    = b[3:0];
          end
          if (offs == 2) ip_total_len[15:8] = b;
          if (offs == 3) ip_total_len[7:0] = b;
          if (offs == 8) ttl_is_zero = (b == 8'd0);
          // first header byte always opens a word, the rest only inside ihl*4
          if (offs == 0 || offs < count_t'({ihl_words, 2'b00})) begin
            if (!offs[0]) begin
              sum_hi_byte = b;
            end else begin
              s = {1'b0, hdr_sum} + {1'b0, sum_hi_byte, b};
              hdr_sum = s[15:0] + 16'(s[16]);
            end
          end
        end
        bytes_seen = seen;

        if (frame_i.last_byte) begin
          ok = (seen >= MinFrameLen) && version_is_4 && (ihl_words >= MinIhl)
            && (ip_total_len >= 16'({ihl_words, 2'b00}))
            && (int'(ip_total_len) + int'(EthHdrLen) <= int'(seen))
            && !ttl_is_zero && (hdr_sum == SumGood);
          v.frame_ok = ok;
          v.frame_no = frames_closed;
          expected_verdicts.push_back(v);
          frames_closed++;
          clear_frame_state();
        end
      end
      awaiting_o <= expected_verdicts.size();
    end
  end

endmodule

/* tb/sv/ipv4_frame_header_validator_tb.sv */
`timescale 1ns / 100ps

module ipv4_frame_header_validator_tb;
  import ifhv_pkg::*;

  localparam int unsigned WatchdogLimit = 4000;

  logic        clk;
  logic        rst_n;
  bit          steady;
  int unsigned mismatches;
  int unsigned awaiting;
  int unsigned quiet_cycles;
  logic [7:0]  frame_bytes[$];

  ifhv_byte_if frame_if ();
  ifhv_res_if  res_if ();

  ipv4_frame_header_validator dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .frame_i (frame_if),
    .result_o(res_if)
  );

  ipv4_header_verdict_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .frame_i     (frame_if),
    .result_i    (res_if),
    .mismatches_o(mismatches),
    .awaiting_o  (awaiting)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (frame_if.valid && frame_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("ipv4_frame_header_validator_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side back-pressure
  initial begin
    int unsigned stall_left;
    int unsigned r;
    stall_left = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n || stall_left != 0) begin
        res_if.ready <= 1'b0;
        if (stall_left != 0) stall_left--;
      end else begin
        res_if.ready <= 1'b1;
        r = $urandom_range(0, 99);
        if (!steady && r >= 75) begin
          stall_left = (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 50);
        end
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ethernet and ipv4 headers (fixed-up checksum), cut or padded to total_len
  function automatic void build_ipv4_frame(input logic [3:0] ver, input logic [3:0] ihl,
                                           input logic [15:0] tot_len, input logic [7:0] ttl,
                                           input bit sum_ok, input int unsigned total_len,
                                           input bit all_ones);
    logic [7:0]  hdr[$];
    int unsigned hdr_len;
    logic [16:0] acc;
    logic [15:0] csum;
    hdr_len = (ihl < 5) ? 20 : int'(ihl) * 4;
    frame_bytes.delete();
    for (int i = 0; i < int'(EthHdrLen); i++) begin
      frame_bytes.push_back(all_ones ? 8'hFF : 8'($urandom));
    end
    for (int i = 0; i < hdr_len; i++) hdr.push_back(all_ones ? 8'hFF : 8'($urandom));
    hdr[0]  = {ver, ihl};
    hdr[2]  = tot_len[15:8];
    hdr[3]  = tot_len[7:0];
    hdr[8]  = ttl;
    hdr[10] = 8'h00;
    hdr[11] = 8'h00;
    csum = '0;
    for (int i = 0; i < hdr_len; i += 2) begin
      acc = {1'b0, csum} + {1'b0, hdr[i], hdr[i+1]};
      csum = acc[15:0] + 16'(acc[16]);
    end
    csum = ~csum;
    if (!sum_ok) csum ^= 16'(1 << $urandom_range(0, 15));
    hdr[10] = csum[15:8];
    hdr[11] = csum[7:0];
    foreach (hdr[i]) frame_bytes.push_back(hdr[i]);
    while (frame_bytes.size() < total_len) begin
      frame_bytes.push_back(all_ones ? 8'hFF : 8'($urandom));
    end
    while (frame_bytes.size() > total_len) void'(frame_bytes.pop_back());
  endfunction

  // fill below zero means random bytes
  function automatic void build_raw(input int unsigned len, input int fill);
    frame_bytes.delete();
    for (int i = 0; i < len; i++) frame_bytes.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last, input int unsigned gap);
    frame_if.valid      <= 1'b1;
    frame_if.frame_byte <= b;
    frame_if.last_byte  <= last;
    do @(posedge clk); while (!frame_if.ready);
    if (gap != 0) begin
      frame_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_bytes.size(); i++) begin
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1, pick_gap());
    end
  endtask

  // hold the sender off until every verdict is back
  task automatic wait_results();
    frame_if.valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned rand_frames;
    int unsigned rand_bytes;
    int unsigned pick;
    int unsigned ihl;
    int unsigned tot;
    int unsigned ttl;
    int unsigned len;
    logic [3:0]  ver;
    bit          sum_ok;

    rst_n = 1'b0;
    steady = 1'b0;
    frame_if.valid      <= 1'b0;
    frame_if.frame_byte <= 8'h00;
    frame_if.last_byte  <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // good headers: minimal with exact fit, full options, padded frame
    build_ipv4_frame(4'd4, 4'd5, 16'd20, 8'd64, 1'b1, 34, 1'b0);
    send_frame();
    build_ipv4_frame(4'd4, 4'd15, 16'd60, 8'd128, 1'b1, 79, 1'b0);
    send_frame();
    build_ipv4_frame(4'd4, 4'd5, 16'd46, 8'd1, 1'b1, 60, 1'b0);
    send_frame();
    // one broken field each
    build_ipv4_frame(4'd6, 4'd5, 16'd20, 8'd64, 1'b1, 34, 1'b0);
    send_frame();
    build_ipv4_frame(4'd4, 4'd0, 16'd20, 8'd64, 1'b1, 34, 1'b0);
    send_frame();
    build_ipv4_frame(4'd4, 4'd4, 16'd20, 8'd64, 1'b1, 34, 1'b0);
    send_frame();
    build_ipv4_frame(4'd4, 4'd6, 16'd20, 8'd64, 1'b1, 40, 1'b0);
    send_frame();
    build_ipv4_frame(4'd4, 4'd5, 16'd27, 8'd64, 1'b1, 40, 1'b0);
    send_frame();
    build_ipv4_frame(4'd4, 4'd5, 16'd20, 8'd0, 1'b1, 34, 1'b0);
    send_frame();
    build_ipv4_frame(4'd4, 4'd5, 16'd20, 8'd64, 1'b0, 34, 1'b0);
    send_frame();
    build_ipv4_frame(4'd4, 4'd5, 16'hFFFF, 8'd64, 1'b1, 60, 1'b0);
    send_frame();
    // all-ones filler bytes exercise the end-around carry
    build_ipv4_frame(4'd4, 4'd15, 16'd60, 8'd255, 1'b1, 80, 1'b1);
    send_frame();
    // all-zero header sums to zero, never all ones
    build_raw(34, 0);
    send_frame();
    // short frames
    build_raw(1, -1);
    send_frame();
    build_raw(14, -1);
    send_frame();
    build_ipv4_frame(4'd4, 4'd5, 16'd19, 8'd64, 1'b1, 33, 1'b0);
    send_frame();
    build_raw(33, 255);
    send_frame();
    wait_results();

    rand_frames = 0;
    rand_bytes = 0;
    while (rand_frames < 10 || rand_bytes < 620) begin
      if ($urandom_range(0, 99) < 12) steady = ~steady;
      pick   = $urandom_range(0, 99);
      ihl    = $urandom_range(0, 1) ? 5 : $urandom_range(5, 15);
      tot    = ihl * 4 + $urandom_range(0, 30);
      ver    = 4'd4;
      ttl    = $urandom_range(1, 255);
      sum_ok = 1'b1;
      len    = int'(EthHdrLen) + tot + $urandom_range(0, 6);
      if (pick >= 70 && pick < 88) begin
        case ($urandom_range(0, 6))
          0: ver = 4'($urandom_range(0, 15));
          1: ttl = 0;
          2: sum_ok = 1'b0;
          3: len = $urandom_range(1, int'(EthHdrLen) + tot - 1);
          4: tot = $urandom_range(0, ihl * 4 - 1);
          5: ihl = $urandom_range(0, 4);
          default: tot = $urandom_range(0, 16'hFFFF);
        endcase
      end
      if (pick >= 88) begin
        build_raw($urandom_range(1, 70), -1);
      end else begin
        build_ipv4_frame(ver, 4'(ihl), 16'(tot), 8'(ttl), sum_ok, len, 1'b0);
      end
      rand_bytes += frame_bytes.size();
      rand_frames++;
      send_frame();
      if (rand_frames % 5 == 0) wait_results();
    end

    wait_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("ipv4_frame_header_validator_tb: PASS");
    end else begin
      $display("ipv4_frame_header_validator_tb: FAIL");
    end
    $finish;
  end

endmodule
